>>> design/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, character codes and literal tables for the request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlp_pkg;

   // verdict codes
   localparam logic [1:0] VERDICT_MORE = 2'd0;
   localparam logic [1:0] VERDICT_DONE = 2'd1;
   localparam logic [1:0] VERDICT_BAD  = 2'd2;

   // byte tag codes
   localparam logic [1:0] TAG_OTHER = 2'd0;
   localparam logic [1:0] TAG_URL   = 2'd1;
   localparam logic [1:0] TAG_HOST  = 2'd2;

   // request line field phases
   localparam logic [2:0] RQ_METHOD  = 3'd0;
   localparam logic [2:0] RQ_GAP1    = 3'd1;
   localparam logic [2:0] RQ_URL     = 3'd2;
   localparam logic [2:0] RQ_GAP2    = 3'd3;
   localparam logic [2:0] RQ_VERSION = 3'd4;

   // header line field phases
   localparam logic [2:0] HD_START = 3'd0;
   localparam logic [2:0] HD_NAME  = 3'd1;
   localparam logic [2:0] HD_GAP   = 3'd2;
   localparam logic [2:0] HD_VALUE = 3'd3;
   localparam logic [2:0] HD_OTHER = 3'd4;

   // URL prefix phases
   localparam logic [1:0] URL_NONE   = 2'd0;
   localparam logic [1:0] URL_SCHEME = 2'd1;
   localparam logic [1:0] URL_HOST   = 2'd2;
   localparam logic [1:0] URL_PATH   = 2'd3;

   // literal lengths
   localparam logic [3:0] LEN_GET  = 4'd3;
   localparam logic [3:0] LEN_VER  = 4'd8;
   localparam logic [3:0] LEN_HTTP = 4'd7;
   localparam logic [3:0] LEN_HOST = 4'd5;

   // characters
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_H     = 8'h68;

   typedef struct packed {
      logic       in_headers;
      logic [2:0] field_phase;
      logic [3:0] match_position;
      logic       after_cr;
      logic       still_matches;
      logic [1:0] url_phase;
   } parse_state_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [1:0] byte_tag;
   } step_result_type;

   localparam parse_state_type RESET_STATE = '{
      in_headers:     1'b0,
      field_phase:    3'd0,
      match_position: 4'd0,
      after_cr:       1'b0,
      still_matches:  1'b1,
      url_phase:      2'd0
   };

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic [7:0] lit_get(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h67; // g
         2'd1:    r = 8'h65; // e
         2'd2:    r = 8'h74; // t
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] lit_ver(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'h68; // h
         3'd1:    r = 8'h74; // t
         3'd2:    r = 8'h74; // t
         3'd3:    r = 8'h70; // p
         3'd4:    r = 8'h2F; // /
         3'd5:    r = 8'h31; // 1
         3'd6:    r = 8'h2E; // .
         default: r = 8'h31; // 1
      endcase
      return r;
   endfunction

   function automatic logic [7:0] lit_http(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'h68; // h
         3'd1:    r = 8'h74; // t
         3'd2:    r = 8'h74; // t
         3'd3:    r = 8'h70; // p
         3'd4:    r = 8'h3A; // :
         3'd5:    r = 8'h2F; // /
         3'd6:    r = 8'h2F; // /
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] lit_host(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'h68; // h
         3'd1:    r = 8'h6F; // o
         3'd2:    r = 8'h73; // s
         3'd3:    r = 8'h74; // t
         3'd4:    r = 8'h3A; // :
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/hrlp_step.sv
// ----------------------------------------------------------------------------
// hrlp_step
// Next-state and result logic for one byte of the request stream.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_step (
   input  wire logic [7:0]               data_byte,
   input  wire hrlp_pkg::parse_state_type cur_state,
   output hrlp_pkg::parse_state_type     nxt_state,
   output hrlp_pkg::step_result_type     result
);

   logic [7:0] lc;
   logic       gap;
   logic       do_url;
   logic       do_ver;

   always_comb begin
      lc     = hrlp_pkg::to_lower(data_byte);
      gap    = (data_byte == hrlp_pkg::CH_SP) || (data_byte == hrlp_pkg::CH_TAB);
      do_url = 1'b0;
      do_ver = 1'b0;
      nxt_state       = cur_state;
      result.verdict  = hrlp_pkg::VERDICT_MORE;
      result.byte_tag = hrlp_pkg::TAG_OTHER;

      if (cur_state.after_cr) begin
         nxt_state.after_cr = 1'b0;
         if (data_byte == hrlp_pkg::CH_LF) begin
            if (!cur_state.in_headers) begin
               if (cur_state.still_matches && cur_state.field_phase == hrlp_pkg::RQ_VERSION &&
                   cur_state.match_position == hrlp_pkg::LEN_VER) begin
                  nxt_state            = hrlp_pkg::RESET_STATE;
                  nxt_state.in_headers = 1'b1;
               end else begin
                  nxt_state      = hrlp_pkg::RESET_STATE;
                  result.verdict = hrlp_pkg::VERDICT_BAD;
               end
            end else if (cur_state.field_phase == hrlp_pkg::HD_START) begin
               nxt_state      = hrlp_pkg::RESET_STATE;
               result.verdict = hrlp_pkg::VERDICT_DONE;
            end else begin
               nxt_state.field_phase    = hrlp_pkg::HD_START;
               nxt_state.match_position = 4'd0;
            end
         end else begin
            nxt_state      = hrlp_pkg::RESET_STATE;
            result.verdict = hrlp_pkg::VERDICT_BAD;
         end
      end else if (data_byte == hrlp_pkg::CH_CR) begin
         nxt_state.after_cr = 1'b1;
      end else if (data_byte == hrlp_pkg::CH_LF) begin
         nxt_state      = hrlp_pkg::RESET_STATE;
         result.verdict = hrlp_pkg::VERDICT_BAD;
      end else if (cur_state.in_headers) begin
         if (nxt_state.field_phase == hrlp_pkg::HD_START) begin
            nxt_state.field_phase    = hrlp_pkg::HD_NAME;
            nxt_state.match_position = 4'd0;
         end
         case (nxt_state.field_phase)
            hrlp_pkg::HD_NAME: begin
               if (nxt_state.match_position < hrlp_pkg::LEN_HOST &&
                   lc == hrlp_pkg::lit_host(nxt_state.match_position[2:0])) begin
                  nxt_state.match_position = nxt_state.match_position + 4'd1;
                  if (nxt_state.match_position == hrlp_pkg::LEN_HOST) begin
                     nxt_state.field_phase = hrlp_pkg::HD_GAP;
                  end
               end else begin
                  nxt_state.field_phase = hrlp_pkg::HD_OTHER;
               end
            end
            hrlp_pkg::HD_GAP: begin
               if (!gap) begin
                  nxt_state.field_phase = hrlp_pkg::HD_VALUE;
                  result.byte_tag       = hrlp_pkg::TAG_HOST;
               end
            end
            hrlp_pkg::HD_VALUE: begin
               result.byte_tag = hrlp_pkg::TAG_HOST;
            end
            default: begin
            end
         endcase
      end else begin
         case (cur_state.field_phase)
            hrlp_pkg::RQ_METHOD: begin
               if (gap) begin
                  if (cur_state.match_position != hrlp_pkg::LEN_GET) begin
                     nxt_state.still_matches = 1'b0;
                  end
                  nxt_state.field_phase    = hrlp_pkg::RQ_GAP1;
                  nxt_state.match_position = 4'd0;
               end else if (cur_state.match_position < hrlp_pkg::LEN_GET &&
                            lc == hrlp_pkg::lit_get(cur_state.match_position[1:0])) begin
                  nxt_state.match_position = cur_state.match_position + 4'd1;
               end else begin
                  nxt_state.still_matches = 1'b0;
               end
            end
            hrlp_pkg::RQ_GAP1: begin
               if (!gap) begin
                  nxt_state.field_phase    = hrlp_pkg::RQ_URL;
                  nxt_state.match_position = 4'd0;
                  do_url                   = 1'b1;
               end
            end
            hrlp_pkg::RQ_URL: begin
               if (gap) begin
                  if (cur_state.url_phase != hrlp_pkg::URL_PATH) begin
                     nxt_state.still_matches = 1'b0;
                  end
                  nxt_state.field_phase    = hrlp_pkg::RQ_GAP2;
                  nxt_state.match_position = 4'd0;
               end else begin
                  do_url = 1'b1;
               end
            end
            hrlp_pkg::RQ_GAP2: begin
               if (!gap) begin
                  nxt_state.field_phase    = hrlp_pkg::RQ_VERSION;
                  nxt_state.match_position = 4'd0;
                  do_ver                   = 1'b1;
               end
            end
            default: begin
               do_ver = 1'b1;
            end
         endcase

         // URL byte: optional scheme and host prefix match, then path
         if (do_url && nxt_state.still_matches) begin
            case (nxt_state.url_phase)
               hrlp_pkg::URL_NONE: begin
                  if (data_byte == hrlp_pkg::CH_SLASH) begin
                     nxt_state.url_phase = hrlp_pkg::URL_PATH;
                     result.byte_tag     = hrlp_pkg::TAG_URL;
                  end else if (lc == hrlp_pkg::CH_H) begin
                     nxt_state.url_phase      = hrlp_pkg::URL_SCHEME;
                     nxt_state.match_position = 4'd1;
                  end else begin
                     nxt_state.still_matches = 1'b0;
                  end
               end
               hrlp_pkg::URL_SCHEME: begin
                  if (nxt_state.match_position < hrlp_pkg::LEN_HTTP &&
                      lc == hrlp_pkg::lit_http(nxt_state.match_position[2:0])) begin
                     nxt_state.match_position = nxt_state.match_position + 4'd1;
                     if (nxt_state.match_position == hrlp_pkg::LEN_HTTP) begin
                        nxt_state.url_phase = hrlp_pkg::URL_HOST;
                     end
                  end else begin
                     nxt_state.still_matches = 1'b0;
                  end
               end
               hrlp_pkg::URL_HOST: begin
                  if (data_byte == hrlp_pkg::CH_SLASH) begin
                     nxt_state.url_phase = hrlp_pkg::URL_PATH;
                     result.byte_tag     = hrlp_pkg::TAG_URL;
                  end
               end
               default: begin
                  result.byte_tag = hrlp_pkg::TAG_URL;
               end
            endcase
         end

         // version literal match
         if (do_ver) begin
            if (nxt_state.match_position < hrlp_pkg::LEN_VER &&
                lc == hrlp_pkg::lit_ver(nxt_state.match_position[2:0])) begin
               nxt_state.match_position = nxt_state.match_position + 4'd1;
            end else begin
               nxt_state.still_matches = 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> design/http_request_line_parser.sv
// Datapath: an accepted byte is held in the input register, then passes through the
//   parser into the output register, from which its result is taken.
// Throughput: one byte per cycle unless rsp_stall holds the output register full.
// Reset (synchronous, active high): empties both registers and returns the parser
//   to the start of a request line.
// ----------------------------------------------------------------------------
// http_request_line_parser
// Byte-stream HTTP GET request parser: gives a verdict and a tag for every byte.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_line_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   // request byte channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_verdict,
   output logic [1:0]      rsp_byte_tag,
   output logic [7:0]      rsp_echo_byte
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parse state, advanced once per byte moved into the output register
   hrlp_pkg::parse_state_type state_ff, state_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_verdict_ff;
   logic [1:0] out_tag_ff;
   logic [7:0] out_byte_ff;

   hrlp_pkg::step_result_type step_result;

   logic out_ready;
   logic advance;
   logic take_req;

   hrlp_step u_step (
      .data_byte (in_byte_ff),
      .cur_state (state_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   // Output register can take a new item when empty or being drained this cycle.
   assign out_ready = !out_valid_ff || !rsp_stall;
   // Advance the held byte through the parser into the output register.
   assign advance   = in_valid_ff && out_ready;
   // Hold the input side only when the input register is full and cannot move on.
   assign req_stall = in_valid_ff && !out_ready;
   assign take_req  = req_valid && !req_stall;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hrlp_pkg::RESET_STATE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         out_verdict_ff <= step_result.verdict;
         out_tag_ff     <= step_result.byte_tag;
         out_byte_ff    <= in_byte_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_verdict   = out_verdict_ff;
   assign rsp_byte_tag  = out_tag_ff;
   assign rsp_echo_byte = out_byte_ff;

   // Any final verdict restarts the parser from the top of a request.
   a_restart_after_verdict : assert property (@(posedge clock) disable iff (reset)
      (advance && step_result.verdict != hrlp_pkg::VERDICT_MORE)
      |=> (state_ff == hrlp_pkg::RESET_STATE))
      else $error("parser did not restart after a verdict");

   // A final verdict is never given on a tagged byte.
   a_verdict_untagged : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict != hrlp_pkg::VERDICT_MORE)
      |-> (rsp_byte_tag == hrlp_pkg::TAG_OTHER))
      else $error("tagged byte carries a final verdict");

   // Line terminators are never tagged.
   a_crlf_untagged : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_echo_byte == hrlp_pkg::CH_CR || rsp_echo_byte == hrlp_pkg::CH_LF))
      |-> (rsp_byte_tag == hrlp_pkg::TAG_OTHER))
      else $error("CR or LF byte tagged");

   // Header phase is only reached through a valid request line.
   a_headers_valid : assert property (@(posedge clock) disable iff (reset)
      state_ff.in_headers |-> state_ff.still_matches)
      else $error("header phase entered with a bad request line");

endmodule

`default_nettype wire
